### src/sfp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and crc helper for the serial frame parser
package sfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sfp_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic        extended;
    logic [15:0] command;
    logic [15:0] flag_word;
    logic [15:0] group_word;
    logic [15:0] standard_data;
  } sfp_out_t;

  typedef struct packed {
    logic [7:0]  ext_code;
    logic [7:0]  std_code;
    logic [15:0] status_cmd;
  } sfp_cfg_t;

  typedef struct packed {
    logic       in_range;
    logic       crc_en;
    logic       pay_zone;
    logic       is_proto;
    logic       hdr_en;
    logic [2:0] hdr_idx;
    logic       too_short;
    logic       short_status;
    logic       std_long;
  } sfp_cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    sfp_cls_t   cls;
  } sfp_entry_t;

  localparam logic [1:0] RegExtCode   = 2'd0;
  localparam logic [1:0] RegStdCode   = 2'd1;
  localparam logic [1:0] RegStatusCmd = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadCrc  = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;

  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'h0000;

  localparam int CrcStart     = 3;
  localparam int ProtoIndex   = 3;
  localparam int HdrFirst     = 5;
  localparam int HdrLast      = 12;
  localparam int PayloadStart = 11;
  localparam int MinFrameLen  = 7;
  localparam int MinStatusLen = 13;
  localparam int MinStdLen    = 15;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        top;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      top = c[15];
      c = {c[14:0], b[k]};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

### src/serial_frame_parser_crc16.sv
`timescale 1ns / 1ps
// top level of the serial frame parser with crc-16 frame check
//
// input channel: one frame byte per word with a last-byte mark, valid/stall
// output channel: result words, either an extended payload byte (kind 0) or
// the frame summary (kind 1), valid/stall; the summary is always the last
// word caused by the final byte of a frame
// apb port: extended protocol code at 0x0, standard protocol code at 0x4,
// status command code at 0x8; write only while the block is idle
// a byte is written into the two-entry queue at the edge it is accepted and
// its result is loaded from the queue into the output register, where it is
// offered until it is taken; a stalled output register can hold the byte back
// the parser takes one byte per cycle while the output is not stalled, but a
// final byte that causes both a payload word and a summary loads the payload
// word first and stays in the queue until its summary is loaded as well
// reset clears the configuration, the frame state, the queue and the output
// while the output is stalled a byte that needs an output word waits at the
// head of the queue; the two-entry queue then fills and the input stall rises
module serial_frame_parser_crc16 #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  sfp_pkg::sfp_in_t  in_word_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output sfp_pkg::sfp_out_t out_word_o,
  input  logic              out_stall_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  sfp_pkg::sfp_cfg_t   cfg_q, cfg_d;
  sfp_pkg::sfp_entry_t push_entry, pop_entry;
  logic                q_full, q_push, q_valid, q_pop;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        sfp_pkg::RegExtCode:   cfg_d.ext_code   = pwdata[7:0];
        sfp_pkg::RegStdCode:   cfg_d.std_code   = pwdata[7:0];
        sfp_pkg::RegStatusCmd: cfg_d.status_cmd = pwdata[15:0];
        default: ;
      endcase
    end
    case (paddr[3:2])
      sfp_pkg::RegExtCode:   prdata = {24'd0, cfg_q.ext_code};
      sfp_pkg::RegStdCode:   prdata = {24'd0, cfg_q.std_code};
      sfp_pkg::RegStatusCmd: prdata = {16'd0, cfg_q.status_cmd};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_word_i (in_word_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (push_entry)
  );

  sfp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(pop_entry)
  );

  sfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ent_valid_i(q_valid),
    .ent_i      (pop_entry),
    .ent_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .out_stall_i(out_stall_i)
  );

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status != 2'd3)
    else $error("undefined status code on output");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind == sfp_pkg::KindPayload) |->
      (out_word_o.status == sfp_pkg::StatusOk && !out_word_o.extended
       && out_word_o.command == 16'd0))
    else $error("payload word carries summary fields");

  a_bad_crc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind == sfp_pkg::KindSummary
     && out_word_o.status == sfp_pkg::StatusBadCrc) |->
      (!out_word_o.extended && out_word_o.command == 16'd0
       && out_word_o.flag_word == 16'd0))
    else $error("bad crc summary carries header fields");

endmodule

### src/sfp_front.sv
`timescale 1ns / 1ps
// front end: takes input words, tracks byte position and classifies each byte
module sfp_front #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sfp_pkg::sfp_in_t    in_word_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sfp_pkg::sfp_entry_t q_entry_o
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [PW:0]   len;
  logic          in_range;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    in_range = pos_q < PW'(MAX_FRAME_BYTES);
    len      = {1'b0, pos_q} + (PW + 1)'(1);

    q_entry_o.data_byte        = in_word_i.data_byte;
    q_entry_o.last_byte        = in_word_i.last_byte;
    q_entry_o.cls.in_range     = in_range;
    q_entry_o.cls.crc_en       = pos_q >= PW'(sfp_pkg::CrcStart);
    q_entry_o.cls.pay_zone     = pos_q >= PW'(sfp_pkg::PayloadStart);
    q_entry_o.cls.is_proto     = pos_q == PW'(sfp_pkg::ProtoIndex);
    q_entry_o.cls.hdr_en       = in_range && (pos_q >= PW'(sfp_pkg::HdrFirst))
                                 && (pos_q <= PW'(sfp_pkg::HdrLast));
    q_entry_o.cls.hdr_idx      = 3'(pos_q - PW'(sfp_pkg::HdrFirst));
    q_entry_o.cls.too_short    = len < (PW + 1)'(sfp_pkg::MinFrameLen);
    q_entry_o.cls.short_status = len < (PW + 1)'(sfp_pkg::MinStatusLen);
    q_entry_o.cls.std_long     = len >= (PW + 1)'(sfp_pkg::MinStdLen);

    pos_d = pos_q;
    if (q_push_o) begin
      if (in_word_i.last_byte) begin
        pos_d = '0;
      end else if (in_range) begin
        pos_d = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

### src/sfp_fifo.sv
`timescale 1ns / 1ps
// two-entry queue between the front and back ends
module sfp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfp_pkg::sfp_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output sfp_pkg::sfp_entry_t entry_o
);

  sfp_pkg::sfp_entry_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign entry_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

### src/sfp_back.sv
`timescale 1ns / 1ps
// back end: crc, hold line, header capture, payload and summary words
module sfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfp_pkg::sfp_cfg_t   cfg_i,
  input  logic                ent_valid_i,
  input  sfp_pkg::sfp_entry_t ent_i,
  output logic                ent_pop_o,
  output logic                out_valid_o,
  output sfp_pkg::sfp_out_t   out_word_o,
  input  logic                out_stall_i
);

  logic [15:0] crc_q, crc_d, crc_n;
  logic [7:0]  hold0_q, hold0_d;
  logic [7:0]  hold1_q, hold1_d;
  logic [7:0]  proto_q, proto_d, proto_n;
  logic [7:0]  hdr_q [8];
  logic [7:0]  hdr_d [8];
  logic [7:0]  hdr_n [8];
  logic        pay_done_q, pay_done_d;
  logic        out_valid_q, out_valid_d;
  sfp_pkg::sfp_out_t out_q, out_d;

  sfp_pkg::sfp_cls_t cls;
  sfp_pkg::sfp_out_t pay_res, sum_res;
  logic [15:0] trailer, cmd;
  logic        want_pay, want_sum, split, can_load, needs_out, step;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    cls       = ent_i.cls;
    want_pay  = cls.in_range && cls.pay_zone && (proto_q == cfg_i.ext_code) && !pay_done_q;
    want_sum  = ent_i.last_byte;
    split     = want_pay && want_sum;
    can_load  = !out_valid_q || !out_stall_i;
    needs_out = want_pay || want_sum;
    step      = ent_valid_i && (can_load || !needs_out);
    ent_pop_o = step && !split;

    crc_n   = cls.crc_en ? sfp_pkg::crc_fold(crc_q, hold1_q) : crc_q;
    proto_n = cls.is_proto ? ent_i.data_byte : proto_q;
    hdr_n   = hdr_q;
    if (cls.hdr_en) begin
      hdr_n[cls.hdr_idx] = ent_i.data_byte;
    end
    trailer = {ent_i.data_byte, hold0_q};

    pay_res              = '0;
    pay_res.kind         = sfp_pkg::KindPayload;
    pay_res.payload_byte = hold1_q;

    cmd             = {hdr_n[1], hdr_n[0]};
    sum_res         = '0;
    sum_res.kind    = sfp_pkg::KindSummary;
    if (!cls.in_range || cls.too_short) begin
      sum_res.status = sfp_pkg::StatusUnknown;
    end else if (crc_n != trailer) begin
      sum_res.status = sfp_pkg::StatusBadCrc;
    end else if (proto_n == cfg_i.ext_code) begin
      sum_res.extended  = 1'b1;
      sum_res.command   = cmd;
      sum_res.flag_word = {hdr_n[3], hdr_n[2]};
      sum_res.status    = (cmd == cfg_i.status_cmd && cls.short_status) ?
                          sfp_pkg::StatusUnknown : sfp_pkg::StatusOk;
    end else if (proto_n == cfg_i.std_code && cls.std_long) begin
      sum_res.status        = sfp_pkg::StatusOk;
      sum_res.command       = {hdr_n[3], hdr_n[2]};
      sum_res.flag_word     = {hdr_n[7], hdr_n[6]};
      sum_res.group_word    = {hdr_n[1], hdr_n[0]};
      sum_res.standard_data = {hdr_n[5], hdr_n[4]};
    end else begin
      sum_res.status = sfp_pkg::StatusUnknown;
    end

    crc_d      = crc_q;
    hold0_d    = hold0_q;
    hold1_d    = hold1_q;
    proto_d    = proto_q;
    hdr_d      = hdr_q;
    pay_done_d = pay_done_q;
    if (step && split) begin
      pay_done_d = 1'b1;
    end
    if (ent_pop_o) begin
      pay_done_d = 1'b0;
      if (ent_i.last_byte) begin
        crc_d   = sfp_pkg::CrcInit;
        hold0_d = '0;
        hold1_d = '0;
        proto_d = '0;
        for (int i = 0; i < 8; i++) begin
          hdr_d[i] = '0;
        end
      end else if (cls.in_range) begin
        crc_d   = crc_n;
        hold0_d = ent_i.data_byte;
        hold1_d = hold0_q;
        proto_d = proto_n;
        hdr_d   = hdr_n;
      end
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step && needs_out) begin
      out_valid_d = 1'b1;
      out_d       = want_pay ? pay_res : sum_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= sfp_pkg::CrcInit;
      hold0_q     <= '0;
      hold1_q     <= '0;
      proto_q     <= '0;
      for (int i = 0; i < 8; i++) begin
        hdr_q[i] <= '0;
      end
      pay_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      hold0_q     <= hold0_d;
      hold1_q     <= hold1_d;
      proto_q     <= proto_d;
      hdr_q       <= hdr_d;
      pay_done_q  <= pay_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the serial frame parser with crc-16 frame check
module tb_top;

  localparam int MaxFrameBytes = 256;
  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 8;
  localparam logic [15:0] PolyMask = 16'h1021;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  sfp_pkg::sfp_in_t  in_word_i;
  logic              in_stall_o;
  logic              out_valid_o;
  sfp_pkg::sfp_out_t out_word_o;
  logic              out_stall_i;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  serial_frame_parser_crc16 #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .out_stall_i(out_stall_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor configuration and frame state
  logic [7:0]  cfg_ext_code;
  logic [7:0]  cfg_std_code;
  logic [15:0] cfg_status_cmd;
  int          frame_len;
  logic [15:0] frame_crc;
  logic [7:0]  delay_line [2];
  logic [7:0]  proto_seen;
  logic [7:0]  header_seen [8];
  logic        too_long;

  sfp_pkg::sfp_out_t expected_words [$];
  logic [7:0]  frame_q [$];
  int          errors;
  int          bytes_sent;
  int          cycle_count;
  bit          no_idle;
  int          hold_req;
  int          hold_left;
  int          stall_left;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: long hold on request, else random stall bursts
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void note_mismatch(string name, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      note_mismatch(name, {16'h0000, want}, {16'h0000, got});
    end
  endfunction

  always @(posedge clk_i) begin
    sfp_pkg::sfp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output word %h", out_word_o);
        end
      end else begin
        want = expected_words.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_word_o.kind));
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_word_o.payload_byte));
        check_field("status", 16'(want.status), 16'(out_word_o.status));
        check_field("extended", 16'(want.extended), 16'(out_word_o.extended));
        check_field("command", want.command, out_word_o.command);
        check_field("flag_word", want.flag_word, out_word_o.flag_word);
        check_field("group_word", want.group_word, out_word_o.group_word);
        check_field("standard_data", want.standard_data, out_word_o.standard_data);
      end
    end
  end

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] din);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = {r[14:0], din[k]} ^ (r[15] ? PolyMask : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [15:0] header_word(int lo);
    return {header_seen[lo - 4], header_seen[lo - 5]};
  endfunction

  function automatic void clear_frame_state();
    frame_len = 0;
    frame_crc = 16'h0000;
    delay_line[0] = 8'h00;
    delay_line[1] = 8'h00;
    proto_seen = 8'h00;
    for (int i = 0; i < 8; i++) begin
      header_seen[i] = 8'h00;
    end
    too_long = 1'b0;
  endfunction

  function automatic void predict_frame_byte(sfp_pkg::sfp_in_t w);
    sfp_pkg::sfp_out_t r;
    logic [15:0]       trailer;
    trailer = 16'h0000;
    if (frame_len >= MaxFrameBytes) begin
      too_long = 1'b1;
    end else begin
      if (frame_len >= 3) begin
        frame_crc = crc16_step(frame_crc, delay_line[1]);
      end
      if (frame_len >= 11 && proto_seen == cfg_ext_code) begin
        r = '0;
        r.kind = sfp_pkg::KindPayload;
        r.payload_byte = delay_line[1];
        expected_words.push_back(r);
      end
      if (frame_len == 3) begin
        proto_seen = w.data_byte;
      end
      if (frame_len >= 5 && frame_len <= 12) begin
        header_seen[frame_len - 5] = w.data_byte;
      end
      trailer = {w.data_byte, delay_line[0]};
      delay_line[1] = delay_line[0];
      delay_line[0] = w.data_byte;
      frame_len++;
    end
    if (w.last_byte) begin
      r = '0;
      r.kind = sfp_pkg::KindSummary;
      if (too_long || frame_len < 7) begin
        r.status = sfp_pkg::StatusUnknown;
      end else if (frame_crc != trailer) begin
        r.status = sfp_pkg::StatusBadCrc;
      end else if (proto_seen == cfg_ext_code) begin
        r.extended = 1'b1;
        r.command = header_word(5);
        r.flag_word = header_word(7);
        r.status = (r.command == cfg_status_cmd && frame_len < 13) ?
                   sfp_pkg::StatusUnknown : sfp_pkg::StatusOk;
      end else if (proto_seen == cfg_std_code && frame_len >= 15) begin
        r.status = sfp_pkg::StatusOk;
        r.command = header_word(7);
        r.flag_word = header_word(11);
        r.group_word = header_word(5);
        r.standard_data = header_word(9);
      end else begin
        r.status = sfp_pkg::StatusUnknown;
      end
      expected_words.push_back(r);
      clear_frame_state();
    end
  endfunction

  task automatic idle_in(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (!no_idle && $urandom_range(0, 6) == 0) begin
      idle_in($urandom_range(1, 4));
    end
  endtask

  task automatic push_byte(logic [7:0] data, logic last);
    sfp_pkg::sfp_in_t w;
    w.data_byte = data;
    w.last_byte = last;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame_byte(w);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    idle_in(1);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(logic [1:0] idx, logic [31:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      note_mismatch("register readback", want, got);
    end
  endtask

  task automatic set_config(logic [7:0] ext, logic [7:0] std, logic [15:0] cmd);
    wait_drain();
    apb_write(sfp_pkg::RegExtCode, {24'h0, ext});
    cfg_ext_code = ext;
    apb_write(sfp_pkg::RegStdCode, {24'h0, std});
    cfg_std_code = std;
    apb_write(sfp_pkg::RegStatusCmd, {16'h0, cmd});
    cfg_status_cmd = cmd;
    apb_read_check(sfp_pkg::RegExtCode, {24'h0, ext});
    apb_read_check(sfp_pkg::RegStdCode, {24'h0, std});
    apb_read_check(sfp_pkg::RegStatusCmd, {16'h0, cmd});
  endtask

  task automatic fill_frame(int len, logic [7:0] proto);
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      frame_q.push_back(8'($urandom));
    end
    if (len > 3) begin
      frame_q[3] = proto;
    end
  endtask

  task automatic put_word(int at, logic [15:0] v);
    frame_q[at] = v[7:0];
    frame_q[at + 1] = v[15:8];
  endtask

  task automatic flip_bit(int at);
    frame_q[at] = frame_q[at] ^ 8'(1 << $urandom_range(0, 7));
  endtask

  task automatic seal_frame();
    logic [15:0] c;
    int          n;
    n = frame_q.size();
    c = 16'h0000;
    if (n >= 3) begin
      for (int i = 1; i + 2 < n; i++) begin
        c = crc16_step(c, frame_q[i]);
      end
      frame_q[n - 2] = c[7:0];
      frame_q[n - 1] = c[15:8];
    end
  endtask

  task automatic send_frame();
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      push_byte(frame_q[i], i == n - 1);
    end
  endtask

  task automatic seal_and_send(int len, logic [7:0] proto);
    fill_frame(len, proto);
    seal_frame();
    send_frame();
  endtask

  task automatic test_reset_config();
    apb_read_check(sfp_pkg::RegExtCode, 32'h0);
    apb_read_check(sfp_pkg::RegStdCode, 32'h0);
    apb_read_check(sfp_pkg::RegStatusCmd, 32'h0);
    // both codes equal: frame counts as extended
    seal_and_send(16, 8'h00);
    seal_and_send(7, 8'h00);
    fill_frame(10, 8'h00);
    put_word(5, 16'h0000);
    seal_frame();
    send_frame();
    wait_drain();
  endtask

  task automatic test_short_frames();
    fill_frame(1, 8'h5A);
    send_frame();
    fill_frame(2, 8'h5A);
    send_frame();
    seal_and_send(3, 8'h5A);
    seal_and_send(6, 8'h5A);
  endtask

  task automatic test_bad_crc();
    fill_frame(20, cfg_ext_code);
    seal_frame();
    flip_bit(19);
    send_frame();
    fill_frame(15, cfg_std_code);
    seal_frame();
    flip_bit(8);
    send_frame();
    fill_frame(7, cfg_ext_code);
    seal_frame();
    flip_bit(1);
    send_frame();
  endtask

  task automatic test_unknown_protocol();
    seal_and_send(16, 8'h00);
    seal_and_send(20, 8'hFF);
  endtask

  task automatic test_standard_frames();
    seal_and_send(15, cfg_std_code);
    seal_and_send(14, cfg_std_code);
    seal_and_send(33, cfg_std_code);
  endtask

  task automatic test_extended_frames();
    seal_and_send(11, cfg_ext_code);
    seal_and_send(12, cfg_ext_code);
    seal_and_send(40, cfg_ext_code);
    fill_frame(12, cfg_ext_code);
    put_word(5, cfg_status_cmd);
    seal_frame();
    send_frame();
    fill_frame(13, cfg_ext_code);
    put_word(5, cfg_status_cmd);
    seal_frame();
    send_frame();
    for (int v = 0; v < 2; v++) begin
      fill_frame(24, cfg_ext_code);
      for (int i = 0; i < 22; i++) begin
        if (i != 3) begin
          frame_q[i] = (v == 0) ? 8'hFF : 8'h00;
        end
      end
      seal_frame();
      send_frame();
    end
  endtask

  task automatic test_overlong();
    seal_and_send(MaxFrameBytes + 1, cfg_ext_code);
  endtask

  task automatic test_code_extremes();
    set_config(8'hFF, 8'h00, 16'hFFFF);
    seal_and_send(18, 8'hFF);
    seal_and_send(16, 8'h00);
    fill_frame(11, 8'hFF);
    put_word(5, 16'hFFFF);
    seal_frame();
    send_frame();
    set_config(8'h00, 8'hFF, 16'h0000);
    seal_and_send(15, 8'hFF);
    fill_frame(13, 8'h00);
    put_word(5, 16'h0000);
    seal_frame();
    send_frame();
  endtask

  task automatic test_backpressure();
    wait_drain();
    no_idle = 1'b1;
    hold_req = 120;
    seal_and_send(60, cfg_ext_code);
    wait_drain();
    no_idle = 1'b0;
  endtask

  task automatic random_frame();
    int          pick;
    logic [7:0]  p;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      seal_and_send($urandom_range(7, 40), cfg_ext_code);
    end else if (pick < 75) begin
      seal_and_send($urandom_range(12, 40), cfg_std_code);
    end else if (pick < 83) begin
      fill_frame($urandom_range(7, 30), $urandom_range(0, 1) ? cfg_ext_code : cfg_std_code);
      seal_frame();
      flip_bit($urandom_range(1, frame_q.size() - 1));
      send_frame();
    end else if (pick < 89) begin
      fill_frame($urandom_range(9, 16), cfg_ext_code);
      put_word(5, cfg_status_cmd);
      seal_frame();
      send_frame();
    end else if (pick < 94) begin
      p = 8'($urandom);
      while (p == cfg_ext_code || p == cfg_std_code) p = 8'($urandom);
      seal_and_send($urandom_range(7, 30), p);
    end else begin
      fill_frame($urandom_range(1, 20), 8'($urandom));
      send_frame();
    end
  endtask

  task automatic test_random_frames();
    logic [7:0] p;
    int         goal;
    for (int phase = 0; phase < 4; phase++) begin
      p = 8'($urandom);
      case (phase)
        0: begin
          set_config(p, p ^ 8'h3C, 16'($urandom));
        end
        1: begin
          set_config(8'hFF, 8'h00, 16'hFFFF);
        end
        2: begin
          set_config(p, p, 16'h0000);
        end
        default: begin
          no_idle = 1'b1;
          set_config(8'h00, 8'hFF, 16'($urandom));
        end
      endcase
      goal = bytes_sent + 25;
      while (bytes_sent < goal) random_frame();
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    bytes_sent = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    hold_req = 0;
    hold_left = 0;
    stall_left = 0;
    cfg_ext_code = 8'h00;
    cfg_std_code = 8'h00;
    cfg_status_cmd = 16'h0000;
    clear_frame_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_config();
    set_config(8'h5A, 8'hA5, 16'h1234);
    test_short_frames();
    test_bad_crc();
    test_unknown_protocol();
    test_standard_frames();
    test_extended_frames();
    test_overlong();
    test_code_extremes();
    test_backpressure();
    test_random_frames();

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
